@@ hw/rtl/mwfh_pkg.sv @@
// Shared constants, status codes and helpers for the mutex unit.
// No dependencies; mwfh_ifs.sv and mutex_with_fifo_handoff.sv use this package.
package mwfh_pkg;

  localparam int MAX_THREADS = 16;               // depth of the waiter queue
  localparam int TID_W       = 4;                // thread id width
  localparam int PTR_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int STATUS_W    = 3;

  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BLOCKED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HANDOFF  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

  // queue pointer advance with wrap at the queue depth
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(MAX_THREADS - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/mwfh_ifs.sv @@
// Valid/ready channel interfaces for request and response words.
// Depends on mwfh_pkg for field widths.
interface mwfh_req_if;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [mwfh_pkg::TID_W-1:0] thread_id;

  modport source (output valid, output cmd, output thread_id, input ready);
  modport sink   (input valid, input cmd, input thread_id, output ready);
endinterface

interface mwfh_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [mwfh_pkg::STATUS_W-1:0] status;
  logic [mwfh_pkg::TID_W-1:0]    woken_thread;
  logic                       is_locked;

  modport source (output valid, output status, output woken_thread, output is_locked,
                  input ready);
  modport sink   (input valid, input status, input woken_thread, input is_locked,
                  output ready);
endinterface

@@ hw/rtl/mutex_with_fifo_handoff.sv @@
// Mutex lock unit with a FIFO wait queue held in a RAM.
// Depends on mwfh_pkg, mwfh_req_if / mwfh_rsp_if and mwfh_ram.
//
// Usage:
//   in_req  : request words {cmd, thread_id}; cmd 0 = lock, 1 = unlock.
//   out_rsp : one response word per request {status, woken_thread, is_locked}.
//   Lock on a free mutex grants it; lock on a held mutex queues the thread
//   (or rejects it when the queue is full). Unlock by the owner hands the
//   mutex to the oldest waiter, or frees it when nobody waits.
// Response: registered once the request is taken; a handoff first passes
//   through S_POP while the queue head is read out of the RAM.
// Throughput: one request per cycle unless stalled; a handoff holds S_POP as
//   the queue RAM read must return before the new owner is known.
// Stall: a response waits in the output register while out_rsp.ready is low;
//   a new request is taken in the same cycle the pending word leaves, so
//   in_req.ready drops only while the output is full and not being drained
//   or while a handoff read is in flight.
// Reset (rst_n low, synchronous): mutex free, owner 0, queue empty, no
//   response pending. Queue RAM contents are not cleared; only entries
//   written by queued lock requests are ever read.
module mutex_with_fifo_handoff (
  input  logic        clk,
  input  logic        rst_n,
  mwfh_req_if.sink    in_req,
  mwfh_rsp_if.source  out_rsp
);

  localparam logic S_IDLE = 1'b0;  // ready for a request
  localparam logic S_POP  = 1'b1;  // waiting on queue head read

  logic                             state_r, state_nxt;
  logic                             held_r, held_nxt;
  logic [mwfh_pkg::TID_W-1:0]       owner_r, owner_nxt;
  logic [mwfh_pkg::PTR_W-1:0]       head_r, head_nxt;
  logic [mwfh_pkg::PTR_W-1:0]       tail_r, tail_nxt;
  logic [mwfh_pkg::CNT_W-1:0]       count_r, count_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [mwfh_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [mwfh_pkg::TID_W-1:0]       out_woken_r, out_woken_nxt;
  logic                             out_locked_r, out_locked_nxt;

  logic                             accept;
  logic                             q_full;
  logic                             ram_we;
  logic [mwfh_pkg::TID_W-1:0]       ram_rdata;

  // waiter queue storage; read port always looks at the head entry
  mwfh_ram #(
    .WIDTH (mwfh_pkg::TID_W),
    .DEPTH (mwfh_pkg::MAX_THREADS)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (in_req.thread_id),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  assign in_req.ready = (state_r == S_IDLE) && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && in_req.ready;
  assign q_full       = (count_r == mwfh_pkg::CNT_W'(mwfh_pkg::MAX_THREADS));

  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    owner_nxt      = owner_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_woken_nxt  = out_woken_r;
    out_locked_nxt = out_locked_r;
    ram_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_woken_nxt = '0;
          if (in_req.cmd == mwfh_pkg::CMD_LOCK) begin
            out_valid_nxt  = 1'b1;
            out_locked_nxt = 1'b1;
            if (!held_r) begin
              held_nxt       = 1'b1;
              owner_nxt      = in_req.thread_id;
              out_status_nxt = mwfh_pkg::ST_GRANTED;
            end else if (q_full) begin
              out_status_nxt = mwfh_pkg::ST_IGNORED;
            end else begin
              ram_we         = 1'b1;
              tail_nxt       = mwfh_pkg::next_ptr(tail_r);
              count_nxt      = count_r + mwfh_pkg::CNT_W'(1);
              out_status_nxt = mwfh_pkg::ST_BLOCKED;
            end
          end else begin
            if (!held_r || (owner_r != in_req.thread_id)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = mwfh_pkg::ST_IGNORED;
              out_locked_nxt = held_r;
            end else if (count_r != '0) begin
              // head entry shows up on the RAM port next cycle
              state_nxt = S_POP;
            end else begin
              out_valid_nxt  = 1'b1;
              held_nxt       = 1'b0;
              owner_nxt      = '0;
              out_status_nxt = mwfh_pkg::ST_RELEASED;
              out_locked_nxt = 1'b0;
            end
          end
        end
      end
      S_POP: begin
        // output register is empty here: request was taken only if it drained
        owner_nxt      = ram_rdata;
        head_nxt       = mwfh_pkg::next_ptr(head_r);
        count_nxt      = count_r - mwfh_pkg::CNT_W'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = mwfh_pkg::ST_HANDOFF;
        out_woken_nxt  = ram_rdata;
        out_locked_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= 1'b0;
      owner_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      owner_r     <= owner_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_woken_r  <= out_woken_nxt;
    out_locked_r <= out_locked_nxt;
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.woken_thread = out_woken_r;
  assign out_rsp.is_locked    = out_locked_r;

`ifndef SYNTHESIS
  // queue occupancy never exceeds its depth
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mwfh_pkg::CNT_W'(mwfh_pkg::MAX_THREADS))
    else $error("waiter count overflow");

  // nobody waits on a free mutex
  a_wait_held: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> held_r)
    else $error("waiters queued on a free mutex");

  // empty queue has aligned pointers
  a_ptr_align: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("queue pointers misaligned while empty");

  // a handoff read never overwrites a pending response
  a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> !out_valid_r)
    else $error("response register busy during handoff");

  // a handoff leaves the mutex held and one fewer waiter
  a_pop_effect: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (held_r && out_valid_r
                            && count_r == $past(count_r) - mwfh_pkg::CNT_W'(1)))
    else $error("handoff did not update owner state");
`endif

endmodule

@@ hw/rtl/mwfh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwfh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ bench/mutex_with_fifo_handoff_test.sv @@
// Self-checking bench for the mutex unit with its FIFO of waiting threads.
// Depends on mwfh_pkg, mwfh_req_if / mwfh_rsp_if and mutex_with_fifo_handoff;
// an in-bench model of the lock predicts each reply word.
module mutex_with_fifo_handoff_test;

  // Run ends here no matter what; the slowest legal run is far below this
  // (about 2000 words with the widest drawn gaps, plus the long receiver hold).
  localparam int CYCLE_LIMIT = 400_000;
  localparam int IDLE_MAX    = 12;   // widest gap either side draws per word
  localparam int TAIL_CYCLES = 10;   // settle time after the last reply

  // One reply word as the checker compares it, field by field.
  typedef struct packed {
    logic [mwfh_pkg::STATUS_W-1:0] status;
    logic [mwfh_pkg::TID_W-1:0]    woken;
    logic                          locked;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  mwfh_req_if req_ch ();
  mwfh_rsp_if rsp_ch ();

  mutex_with_fifo_handoff i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Lock model. Lives entirely in the bench: held flag, owner and the
  // waiter queue (a bounded SV queue stands in for the RAM ring).
  // ---------------------------------------------------------------------
  logic                       mtx_held  = 1'b0;
  logic [mwfh_pkg::TID_W-1:0] mtx_owner = '0;
  logic [mwfh_pkg::TID_W-1:0] waiters[$];

  reply_t due_replies[$];   // replies owed by the block, oldest first
  int     err_count   = 0;
  int     cycle_count = 0;

  // Knobs the tests turn: widest idle gap per word on each side, and a
  // one-shot long hold that the receiver process counts out by itself.
  int tx_gap_max    = IDLE_MAX;
  int rx_stall_max  = IDLE_MAX;
  int rx_hold_cycles = 0;

  // Apply one request to the model and return the reply it must produce.
  function automatic reply_t next_reply(input logic c,
                                        input logic [mwfh_pkg::TID_W-1:0] t);
    reply_t r;
    r.woken = '0;
    if (c == mwfh_pkg::CMD_LOCK) begin
      if (!mtx_held) begin
        mtx_held  = 1'b1;
        mtx_owner = t;
        r.status  = mwfh_pkg::ST_GRANTED;
      end else if (waiters.size() >= mwfh_pkg::MAX_THREADS) begin
        // full queue: rejected, nothing moves
        r.status = mwfh_pkg::ST_IGNORED;
      end else begin
        // held, even by the requester itself: just queue it
        waiters.push_back(t);
        r.status = mwfh_pkg::ST_BLOCKED;
      end
    end else begin
      if (!mtx_held || mtx_owner != t) begin
        r.status = mwfh_pkg::ST_IGNORED;
      end else if (waiters.size() > 0) begin
        r.woken   = waiters.pop_front();
        mtx_owner = r.woken;
        r.status  = mwfh_pkg::ST_HANDOFF;
      end else begin
        // last holder leaves: owner reads back as zero
        mtx_held  = 1'b0;
        mtx_owner = '0;
        r.status  = mwfh_pkg::ST_RELEASED;
      end
    end
    r.locked = mtx_held;
    return r;
  endfunction

  function automatic int draw_idle(input int max_gap);
    int n;
    n = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
    return n;
  endfunction

  // ---------------------------------------------------------------------
  // Sender: idle for a drawn gap, offer the word, hold it until taken.
  // The expectation is pushed from this process at the accepting edge, so
  // the generator can read the model state without a race.
  // ---------------------------------------------------------------------
  task automatic send_request(input logic c, input logic [mwfh_pkg::TID_W-1:0] t);
    int gap;
    gap = draw_idle(tx_gap_max);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.cmd       <= c;
    req_ch.thread_id <= t;
    do @(posedge clk); while (!req_ch.ready);
    due_replies.push_back(next_reply(c, t));
  endtask

  // Sender pause: nothing new until every owed reply has come back.
  task automatic wait_replies_done();
    req_ch.valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
  endtask

  // Random traffic, mostly well formed: unlocks usually come from the
  // current owner so handoffs and releases keep happening. The lock share
  // is redrawn every 40 words so the queue swings between empty and full.
  task automatic run_traffic(input int n_words);
    logic                       c;
    logic [mwfh_pkg::TID_W-1:0] t;
    int                         lock_pct;
    lock_pct = 50;
    for (int i = 0; i < n_words; i++) begin
      if (i % 40 == 0) lock_pct = $urandom_range(25, 80);
      if ($urandom_range(0, 99) < lock_pct) begin
        c = mwfh_pkg::CMD_LOCK;
        t = mwfh_pkg::TID_W'($urandom_range(0, (1 << mwfh_pkg::TID_W) - 1));
      end else begin
        c = mwfh_pkg::CMD_UNLOCK;
        if (mtx_held && $urandom_range(0, 99) < 85) begin
          t = mtx_owner;
        end else begin
          t = mwfh_pkg::TID_W'($urandom_range(0, (1 << mwfh_pkg::TID_W) - 1));
        end
      end
      send_request(c, t);
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: draw a stall before each reply word, then keep ready up
  // until one is taken. A long hold request preempts the wait.
  // ---------------------------------------------------------------------
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = draw_idle(rx_stall_max);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid && rx_hold_cycles == 0);
    end
  end

  // ---------------------------------------------------------------------
  // Reply checker: every word taken is compared with the oldest one owed.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    reply_t exp_w;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (due_replies.size() == 0) begin
        $display("%0t: reply word with none owed: status %0d woken %0d locked %0d",
                 $time, rsp_ch.status, rsp_ch.woken_thread, rsp_ch.is_locked);
        err_count++;
      end else begin
        exp_w = due_replies.pop_front();
        if (rsp_ch.status !== exp_w.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, exp_w.status, rsp_ch.status);
          err_count++;
        end
        if (rsp_ch.woken_thread !== exp_w.woken) begin
          $display("%0t: woken_thread mismatch: expected %0d, got %0d",
                   $time, exp_w.woken, rsp_ch.woken_thread);
          err_count++;
        end
        if (rsp_ch.is_locked !== exp_w.locked) begin
          $display("%0t: is_locked mismatch: expected %0d, got %0d",
                   $time, exp_w.locked, rsp_ch.is_locked);
          err_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d replies still owed", $time, due_replies.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Walk through every status at least once: unlock while free, grant, lock by the
  // owner itself, unlock by a stranger, handoff, release, owner cleared.
  task automatic test_lock_corners();
    send_request(mwfh_pkg::CMD_UNLOCK, 4'd0);    // free: ignored, stays unlocked
    send_request(mwfh_pkg::CMD_LOCK,   4'd15);   // granted
    send_request(mwfh_pkg::CMD_LOCK,   4'd15);   // owner asks again: queued, no recursion
    send_request(mwfh_pkg::CMD_UNLOCK, 4'd0);    // not the owner: ignored
    send_request(mwfh_pkg::CMD_UNLOCK, 4'd15);   // handoff to the queued 15
    send_request(mwfh_pkg::CMD_UNLOCK, 4'd15);   // nobody waits: released
    send_request(mwfh_pkg::CMD_LOCK,   4'd0);    // granted to id zero
    send_request(mwfh_pkg::CMD_UNLOCK, 4'd0);    // released again, owner back to zero
  endtask

  // Fill the waiter queue to the brim with every thread id, then one more
  // lock that must bounce. The full queue is left for the traffic to drain.
  task automatic test_queue_full();
    send_request(mwfh_pkg::CMD_LOCK, 4'd10);
    for (int i = 0; i < mwfh_pkg::MAX_THREADS; i++) begin
      send_request(mwfh_pkg::CMD_LOCK, mwfh_pkg::TID_W'(i));
    end
    send_request(mwfh_pkg::CMD_LOCK, 4'd5);      // queue full: rejected
  endtask

  task automatic test_random_idling();
    tx_gap_max   = IDLE_MAX;
    rx_stall_max = IDLE_MAX;
    run_traffic(600);
  endtask

  // Full rate on both sides: back-to-back words, handoffs one after another.
  task automatic test_back_to_back();
    tx_gap_max   = 0;
    rx_stall_max = 0;
    run_traffic(400);
  endtask

  task automatic test_sender_gaps();
    tx_gap_max   = IDLE_MAX;
    rx_stall_max = 0;
    run_traffic(300);
  endtask

  task automatic test_receiver_stalls();
    tx_gap_max   = 0;
    rx_stall_max = IDLE_MAX;
    run_traffic(300);
  endtask

  // Receiver goes quiet for a long stretch while the sender keeps offering
  // words at full rate, so the output register fills and the input stalls.
  task automatic test_backpressure();
    wait_replies_done();
    tx_gap_max     = 0;
    rx_stall_max   = 2;
    rx_hold_cycles = 80;
    run_traffic(40);
    wait_replies_done();
  endtask

  task automatic test_mixed_tail();
    tx_gap_max   = IDLE_MAX;
    rx_stall_max = IDLE_MAX;
    run_traffic(300);
  endtask

  initial begin
    rst_n            <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.cmd       <= mwfh_pkg::CMD_LOCK;
    req_ch.thread_id <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_lock_corners();
    test_queue_full();
    test_random_idling();
    test_back_to_back();
    test_backpressure();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_tail();

    // drain, then give a late or extra reply a chance to show up
    wait_replies_done();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
